[sv/pcg32_random_with_index_seeding_top_defines.svh]
// Assertion macros shared by the checker of the random number generator.
// No dependencies; included by the checker file.
`ifndef PCG32_RANDOM_WITH_INDEX_SEEDING_TOP_DEFINES_SVH
`define PCG32_RANDOM_WITH_INDEX_SEEDING_TOP_DEFINES_SVH

// Consequent must hold in the cycle after the antecedent.
`define PCGR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// Consequent must hold in the same cycle as the antecedent.
`define PCGR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

[sv/pcgr_pkg.sv]
// Package of the per-ray random number generator: field widths, mixing
// constants and the sequencer state type. No dependencies.
`default_nettype none

package pcgr_pkg;

    localparam int unsigned IndexWidth = 32;
    localparam int unsigned WordWidth  = 32;
    localparam int unsigned FracWidth  = 24;
    localparam int unsigned StateWidth = 64;

    localparam logic [63:0] GOLDEN_GAMMA = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [63:0] MIX_MUL_A    = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [63:0] MIX_MUL_B    = 64'h94D0_49BB_1331_11EB;
    localparam logic [63:0] LCG_MUL      = 64'h5851_F42D_4C95_7F2D;
    localparam logic [63:0] LCG_INC      = 64'h1405_7B7E_F767_814F;
    localparam logic [63:0] PIXEL_SALT   = 64'hD1B5_4A32_D192_ED03;
    localparam logic [63:0] SAMPLE_SALT  = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [63:0] RAY_SALT     = 64'hBF58_476D_1CE4_E5B9;

    localparam logic OP_SEED = 1'b0;
    localparam logic OP_DRAW = 1'b1;

    // Index of the mix being worked on during seeding; the last one is final.
    localparam logic [1:0] MIX_PIXEL  = 2'd0;
    localparam logic [1:0] MIX_SAMPLE = 2'd1;
    localparam logic [1:0] MIX_RAY    = 2'd2;
    localparam logic [1:0] MIX_FINAL  = 2'd3;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_PREP   = 6'b000010,
        ST_MUL_LL = 6'b000100,
        ST_MUL_LH = 6'b001000,
        ST_MUL_HL = 6'b010000,
        ST_FIN    = 6'b100000
    } fsm_t;

    // PCG32 XSH-RR output permutation of a 64-bit state.
    function automatic logic [WordWidth-1:0] xsh_rr(input logic [StateWidth-1:0] s);
        logic [StateWidth-1:0]  folded;
        logic [WordWidth-1:0]   shifted;
        logic [4:0]             rot;
        logic [2*WordWidth-1:0] doubled;
        folded  = s ^ (s >> 18);
        shifted = folded[58:27];
        rot     = s[63:59];
        doubled = {shifted, shifted} >> rot;
        return doubled[WordWidth-1:0];
    endfunction

endpackage

`default_nettype wire

[sv/pcgr_req_if.sv]
// Request channel of the random number generator: seed or draw beats.
// Depends on pcgr_pkg for the field widths.
`default_nettype none

interface pcgr_req_if;
    import pcgr_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  opcode;
    logic [IndexWidth-1:0] pixel_index;
    logic [IndexWidth-1:0] sample_index;
    logic [IndexWidth-1:0] ray_index;

    modport source (output valid, opcode, pixel_index, sample_index, ray_index,
                    input ready);
    modport sink   (input valid, opcode, pixel_index, sample_index, ray_index,
                    output ready);
endinterface

`default_nettype wire

[sv/pcgr_rsp_if.sv]
// Response channel of the random number generator: one beat per draw.
// Depends on pcgr_pkg for the field widths.
`default_nettype none

interface pcgr_rsp_if;
    import pcgr_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [WordWidth-1:0] random_word;
    logic [FracWidth-1:0] unit_fraction;

    modport source (output valid, random_word, unit_fraction, input ready);
    modport sink   (input valid, random_word, unit_fraction, output ready);
endinterface

`default_nettype wire

[sv/pcg32_random_with_index_seeding_top.sv]
// Per-ray PCG32 generator with splitmix64 seeding from pixel, sample and ray
// indices. Depends on pcgr_pkg, pcgr_req_if and pcgr_rsp_if.
//
// Usage:
//   req carries one beat per command. Opcode seed loads the 64-bit state from
//   the three indices and produces no response beat. Opcode draw returns one
//   beat on rsp with the XSH-RR word of the current state and its top 24 bits,
//   then advances the LCG.
//   All 64-bit products come from a single 32x32 multiplier that is used
//   three times per product (low-low, then the two cross terms).
//   A draw passes through the multiply states MUL_LL, MUL_LH and MUL_HL and
//   then ST_FIN, which registers rsp.valid; no new command is taken until idle.
//   A seed runs 4 mixes of 2 products each, each mix a ST_PREP step and then
//   its two products; the next beat is taken only back in idle. req.ready
//   is low throughout.
//   The response sits in an output register; while a stalled receiver holds
//   it, req.ready stays low for seeds and draws alike until the pending beat
//   is taken or is being taken.
//   Reset clears the state to zero, empties the output register and returns
//   the sequencer to idle.
`default_nettype none

module pcg32_random_with_index_seeding_top (
    input  wire logic clk,
    input  wire logic rst_n,
    pcgr_req_if.sink  req,
    pcgr_rsp_if.source rsp
);
    import pcgr_pkg::*;

    fsm_t                  fsm_reg, fsm_next;
    logic [StateWidth-1:0] state_reg, state_next;
    logic                  draw_reg, draw_next;
    logic                  second_reg, second_next;
    logic [1:0]            idx_reg, idx_next;
    logic [StateWidth-1:0] seed_acc_reg, seed_acc_next;
    logic [IndexWidth-1:0] pixel_reg, pixel_next;
    logic [IndexWidth-1:0] sample_reg, sample_next;
    logic [IndexWidth-1:0] ray_reg, ray_next;
    logic [StateWidth-1:0] mul_a_reg, mul_a_next;
    logic [StateWidth-1:0] mul_b_reg, mul_b_next;
    logic [StateWidth-1:0] acc_reg, acc_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    logic [WordWidth-1:0]  word_reg, word_next;

    logic [31:0]           m_x, m_y;
    logic [63:0]           prod;
    logic [StateWidth-1:0] mix_src;
    logic [StateWidth-1:0] mix_pre;
    logic [StateWidth-1:0] mix_out;
    logic                  accept;

    assign req.ready         = (fsm_reg == ST_IDLE) && (!rsp_valid_reg || rsp.ready);
    assign accept            = req.valid && req.ready;
    assign rsp.valid         = rsp_valid_reg;
    assign rsp.random_word   = word_reg;
    assign rsp.unit_fraction = word_reg[WordWidth-1 -: FracWidth];

    // Shared multiplier: operand halves chosen by the multiply step.
    always_comb
    begin
        m_x = '0;
        m_y = '0;
        unique case (fsm_reg)
            ST_MUL_LL:
            begin
                m_x = mul_a_reg[31:0];
                m_y = mul_b_reg[31:0];
            end
            ST_MUL_LH:
            begin
                m_x = mul_a_reg[31:0];
                m_y = mul_b_reg[63:32];
            end
            ST_MUL_HL:
            begin
                m_x = mul_a_reg[63:32];
                m_y = mul_b_reg[31:0];
            end
            default:
            begin
                m_x = '0;
                m_y = '0;
            end
        endcase
    end

    assign prod = {32'd0, m_x} * {32'd0, m_y};

    always_comb
    begin
        unique case (idx_reg)
            MIX_PIXEL:  mix_src = {32'd0, pixel_reg} ^ PIXEL_SALT;
            MIX_SAMPLE: mix_src = {32'd0, sample_reg} ^ SAMPLE_SALT;
            MIX_RAY:    mix_src = {32'd0, ray_reg} ^ RAY_SALT;
            default:    mix_src = seed_acc_reg;
        endcase
    end

    assign mix_pre = mix_src + GOLDEN_GAMMA;
    assign mix_out = acc_reg ^ (acc_reg >> 31);

    always_comb
    begin
        fsm_next       = fsm_reg;
        state_next     = state_reg;
        draw_next      = draw_reg;
        second_next    = second_reg;
        idx_next       = idx_reg;
        seed_acc_next  = seed_acc_reg;
        pixel_next     = pixel_reg;
        sample_next    = sample_reg;
        ray_next       = ray_reg;
        mul_a_next     = mul_a_reg;
        mul_b_next     = mul_b_reg;
        acc_next       = acc_reg;
        word_next      = word_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;

        unique case (fsm_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    pixel_next  = req.pixel_index;
                    sample_next = req.sample_index;
                    ray_next    = req.ray_index;
                    idx_next    = MIX_PIXEL;
                    second_next = 1'b0;
                    if (req.opcode == OP_DRAW)
                    begin
                        draw_next  = 1'b1;
                        mul_a_next = state_reg;
                        mul_b_next = LCG_MUL;
                        fsm_next   = ST_MUL_LL;
                    end
                    else
                    begin
                        draw_next = 1'b0;
                        fsm_next  = ST_PREP;
                    end
                end
            end
            ST_PREP:
            begin
                mul_a_next  = mix_pre ^ (mix_pre >> 30);
                mul_b_next  = MIX_MUL_A;
                second_next = 1'b0;
                fsm_next    = ST_MUL_LL;
            end
            ST_MUL_LL:
            begin
                acc_next = prod;
                fsm_next = ST_MUL_LH;
            end
            ST_MUL_LH:
            begin
                acc_next[63:32] = acc_reg[63:32] + prod[31:0];
                fsm_next        = ST_MUL_HL;
            end
            ST_MUL_HL:
            begin
                acc_next[63:32] = acc_reg[63:32] + prod[31:0];
                fsm_next        = ST_FIN;
            end
            ST_FIN:
            begin
                if (draw_reg)
                begin
                    word_next      = xsh_rr(state_reg);
                    rsp_valid_next = 1'b1;
                    state_next     = acc_reg + LCG_INC;
                    fsm_next       = ST_IDLE;
                end
                else if (!second_reg)
                begin
                    mul_a_next  = acc_reg ^ (acc_reg >> 27);
                    mul_b_next  = MIX_MUL_B;
                    second_next = 1'b1;
                    fsm_next    = ST_MUL_LL;
                end
                else if (idx_reg == MIX_FINAL)
                begin
                    state_next = mix_out;
                    fsm_next   = ST_IDLE;
                end
                else
                begin
                    // The first index mix starts the running XOR afresh.
                    seed_acc_next = (idx_reg == MIX_PIXEL) ? mix_out
                                                           : (seed_acc_reg ^ mix_out);
                    idx_next      = idx_reg + 2'd1;
                    fsm_next      = ST_PREP;
                end
            end
            default:
            begin
                fsm_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg       <= ST_IDLE;
            state_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            draw_reg      <= 1'b0;
            second_reg    <= 1'b0;
            idx_reg       <= MIX_PIXEL;
        end
        else
        begin
            fsm_reg       <= fsm_next;
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            draw_reg      <= draw_next;
            second_reg    <= second_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        seed_acc_reg <= seed_acc_next;
        pixel_reg    <= pixel_next;
        sample_reg   <= sample_next;
        ray_reg      <= ray_next;
        mul_a_reg    <= mul_a_next;
        mul_b_reg    <= mul_b_next;
        acc_reg      <= acc_next;
        word_reg     <= word_next;
    end

endmodule

`default_nettype wire

[sv/pcgr_checker.sv]
// Port-level checker of the random number generator, bound to the top level.
// Depends on pcgr_pkg and the assertion macros header.
`default_nettype none
`include "pcg32_random_with_index_seeding_top_defines.svh"

module pcgr_checker (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            req_valid,
    input wire logic                            req_ready,
    input wire logic                            req_opcode,
    input wire logic                            rsp_valid,
    input wire logic                            rsp_ready,
    input wire logic [pcgr_pkg::WordWidth-1:0]  rsp_random_word
);
    import pcgr_pkg::*;

    logic req_beat;

    assign req_beat = req_valid && req_ready;

    // A response beat waiting on the receiver is held with its word unchanged.
    `PCGR_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready,
                      rsp_valid && $stable(rsp_random_word))

    // Every command keeps the sequencer busy, so req.ready is low in the next cycle.
    `PCGR_ASSERT_NEXT(a_busy_after_beat, clk, rst_n, req_beat, !req_ready)

    // A seed command never produces a response beat.
    `PCGR_ASSERT_NEXT(a_seed_silent, clk, rst_n, req_beat && (req_opcode == OP_SEED),
                      !$rose(rsp_valid))

    // A draw is only taken when the output register is free or being emptied.
    `PCGR_ASSERT_NOW(a_draw_room, clk, rst_n, req_beat && (req_opcode == OP_DRAW),
                     !rsp_valid || rsp_ready)

endmodule

bind pcg32_random_with_index_seeding_top pcgr_checker u_pcgr_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .req_opcode      (req.opcode),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_random_word (rsp.random_word)
);

`default_nettype wire
